/* hdl/vrs_pkg.sv */
// Shared types and constants for the value rank block.
`default_nettype none

package vrs_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 6;

  // One list element as it sits in a cell and moves along the chain.
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
    logic [RANK_W-1:0]         idx;    // arrival position in the list
    logic [RANK_W-1:0]         rank;   // running rank count
  } entry_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic   shift;  // take the neighbor's entry this cycle
    logic   cmp;    // count the broadcast entry against the own entry
    entry_t bcast;  // entry at the tail of the chain
  } cell_ctl_t;

endpackage

`default_nettype wire

/* hdl/vrs_cell.sv */
// One cell of the ranking chain: holds an element and counts the elements that rank below it.
`default_nettype none

module vrs_cell (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  vrs_pkg::cell_ctl_t ctl,
  input  vrs_pkg::entry_t    prev,
  output vrs_pkg::entry_t    pass
);
  import vrs_pkg::*;

  logic                      valid_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [RANK_W-1:0]         idx_r;
  logic [RANK_W-1:0]         rank_r;
  logic                      inc;

  // Broadcast element ranks below ours: smaller, or equal and earlier.
  always_comb begin
    inc = 1'b0;
    if (ctl.cmp && ctl.bcast.valid && valid_r) begin
      if (ctl.bcast.value < value_r) begin
        inc = 1'b1;
      end else if (ctl.bcast.value == value_r && ctl.bcast.idx < idx_r) begin
        inc = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value_r <= prev.value;
      idx_r   <= prev.idx;
      rank_r  <= prev.rank;
    end
  end

  assign pass.valid = valid_r;
  assign pass.value = value_r;
  assign pass.idx   = idx_r;
  assign pass.rank  = rank_r + RANK_W'(inc);

endmodule

`default_nettype wire

/* hdl/value_rank_by_sort.sv */
// Top level of the value rank block: a chain of ranking cells and its sequencer.
`default_nettype none

// Usage
//   Input: a request is taken at a clock edge with start high and busy low.
//   in_value is a signed 32-bit list element, in_is_last closes the list.
//   Elements arrive one per cycle while busy is low; beyond MAX_ITEMS they
//   are dropped, but a dropped element flagged last still closes the list.
//   Output: after the list closes, one result per held element, in arrival
//   order, each on out_rank/out_last_rank for one cycle with out_valid high.
//   out_rank is the stable ascending rank: smaller values plus equal values
//   that arrived earlier. out_last_rank marks the final element's result.
//   Timing: closing the list starts a rotation in which every element
//   passes the chain tail once and every cell compares it with its own
//   element. A drain then shifts the chain toward the tail: the empty cells
//   leave it first, then the n results, one per cycle, one register late.
//   busy stays high from the close of the list until the final result
//   appears, and is low in that result's cycle.
//   The receiver cannot stall; results are never held back.
//   Reset (synchronous, rst_n low) empties the chain and the element count.
module value_rank_by_sort #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic signed [vrs_pkg::VALUE_W-1:0] in_value,
  input  wire logic                              in_is_last,
  output      logic                              out_valid,
  output      logic [vrs_pkg::RANK_W-1:0]        out_rank,
  output      logic                              out_last_rank
);
  import vrs_pkg::*;

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROTATE,
    ST_DRAIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  rot_r, rot_nxt;
  logic              out_valid_r;
  logic [RANK_W-1:0] out_rank_r;
  logic              out_last_rank_r;

  logic      accept;
  logic      load_en;
  logic      emit;
  logic      is_final;
  entry_t    new_entry;
  entry_t    head_in;
  entry_t    tail;
  cell_ctl_t ctl;
  entry_t    pass [MAX_ITEMS];

  assign busy    = (state_r != ST_LOAD);
  assign accept  = start && !busy;
  // Full chain: the element is dropped, only its last flag counts.
  assign load_en = accept && (count_r < CNT_W'(MAX_ITEMS));

  assign tail = pass[MAX_ITEMS-1];

  assign new_entry.valid = 1'b1;
  assign new_entry.value = in_value;
  assign new_entry.idx   = RANK_W'(count_r);
  assign new_entry.rank  = '0;

  // Head of the chain: new elements while loading, the tail while rotating
  // (closing the ring), empty entries while draining.
  always_comb begin
    unique case (state_r)
      ST_ROTATE: head_in = tail;
      ST_DRAIN:  head_in = '0;
      default:   head_in = new_entry;
    endcase
  end

  assign ctl.shift = load_en || (state_r == ST_ROTATE) || (state_r == ST_DRAIN);
  assign ctl.cmp   = (state_r == ST_ROTATE);
  assign ctl.bcast = tail;

  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    if (k == 0) begin : g_head
      vrs_cell u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl),
        .prev (head_in),
        .pass (pass[k])
      );
    end else begin : g_body
      vrs_cell u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl),
        .prev (pass[k-1]),
        .pass (pass[k])
      );
    end
  end

  // Drain: the first element loaded sits deepest, so results leave the
  // tail in arrival order. The element with the highest index ends the list.
  assign emit     = (state_r == ST_DRAIN) && tail.valid;
  assign is_final = (tail.idx == RANK_W'(count_r - CNT_W'(1)));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rot_nxt   = rot_r;
    unique case (state_r)
      ST_LOAD: begin
        if (load_en) begin
          count_nxt = count_r + CNT_W'(1);
        end
        if (accept && in_is_last) begin
          state_nxt = ST_ROTATE;
          rot_nxt   = '0;
        end
      end
      ST_ROTATE: begin
        rot_nxt = rot_r + IDX_W'(1);
        if (rot_r == IDX_W'(MAX_ITEMS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (emit && is_final) begin
          state_nxt = ST_LOAD;
          count_nxt = '0;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rot_r       <= rot_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    out_rank_r      <= tail.rank;
    out_last_rank_r <= is_final;
  end

  assign out_valid     = out_valid_r;
  assign out_rank      = out_rank_r;
  assign out_last_rank = out_last_rank_r;

endmodule

`default_nettype wire

/* hdl/vrs_checker.sv */
// Port-level checks for the value rank block, bound to its top level.
`default_nettype none

module vrs_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_is_last,
  input wire logic out_valid,
  input wire logic out_last_rank
);

  // Closing request starts the ranking pass.
  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_is_last |=> busy)
    else $error("list close did not raise busy");

  // Results only come out of a ranking pass.
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result outside a ranking pass");

  // The final result ends the pass; earlier ones leave it running.
  a_final_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_rank |-> !busy)
    else $error("busy after final result");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_rank |-> busy)
    else $error("idle before final result");

  // Results of one list come on consecutive cycles.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_rank |=> out_valid)
    else $error("gap inside result burst");

endmodule

bind value_rank_by_sort vrs_checker u_vrs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_is_last   (in_is_last),
  .out_valid    (out_valid),
  .out_last_rank(out_last_rank)
);

`default_nettype wire

/* tb/rank_checker.sv */
// Checker for value_rank_by_sort: watches both channels, predicts ranks and compares them.
`default_nettype none

module rank_checker #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic                               busy,
  input  wire logic signed [vrs_pkg::VALUE_W-1:0] in_value,
  input  wire logic                               in_is_last,
  input  wire logic                               out_valid,
  input  wire logic [vrs_pkg::RANK_W-1:0]         out_rank,
  input  wire logic                               out_last_rank,
  output      int                                 fail_cnt,
  output      int                                 ranks_due
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [vrs_pkg::RANK_W-1:0] rank;
    logic                       last;
  } rank_res_t;

  logic signed [vrs_pkg::VALUE_W-1:0] list_vals [MAX_ITEMS];
  int        list_len;
  rank_res_t rank_q [$];

  initial begin
    fail_cnt  = 0;
    ranks_due = 0;
    list_len  = 0;
  end

  // Stable ascending rank of every held element, queued in arrival order.
  task automatic rank_list();
    int        r;
    rank_res_t res;
    for (int i = 0; i < list_len; i++) begin
      r = 0;
      for (int j = 0; j < list_len; j++) begin
        if (list_vals[j] < list_vals[i] || (list_vals[j] == list_vals[i] && j < i))
          r++;
      end
      res.rank = r[vrs_pkg::RANK_W-1:0];
      res.last = (i == list_len - 1);
      rank_q.push_back(res);
    end
    list_len = 0;
  endtask

  always @(posedge clk) begin
    rank_res_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (rank_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("%0t: unexpected rank %0d last %0b", $realtime, out_rank, out_last_rank);
          fail_cnt++;
        end else begin
          want = rank_q.pop_front();
          if (want.rank !== out_rank || want.last !== out_last_rank) begin
            if (fail_cnt < 10)
              $display("%0t: rank mismatch: expected rank %0d last %0b, got rank %0d last %0b",
                       $realtime, want.rank, want.last, out_rank, out_last_rank);
            fail_cnt++;
          end
        end
      end
      // Accepted request: store unless the list is full, close on last.
      if (start && !busy) begin
        if (list_len < MAX_ITEMS) begin
          list_vals[list_len] = in_value;
          list_len++;
        end
        if (in_is_last)
          rank_list();
      end
    end
    ranks_due <= rank_q.size();
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Testbench top for value_rank_by_sort: reset, list stimulus and the final verdict.
`default_nettype none

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ITEMS  = 64;
  localparam int ITEM_GOAL  = 400;
  localparam int CALM_START = 320;  // no idling from here on
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic signed [vrs_pkg::VALUE_W-1:0] in_value = '0;
  logic                               in_is_last = 1'b0;
  logic                               out_valid;
  logic [vrs_pkg::RANK_W-1:0]         out_rank;
  logic                               out_last_rank;

  int fail_cnt;
  int ranks_due;
  int sent_cnt = 0;

  // Values of the list about to be sent.
  logic signed [31:0] list_buf [$];

  always #2 clk = ~clk;

  value_rank_by_sort #(.MAX_ITEMS(MAX_ITEMS)) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .in_is_last   (in_is_last),
    .out_valid    (out_valid),
    .out_rank     (out_rank),
    .out_last_rank(out_last_rank)
  );

  rank_checker #(.MAX_ITEMS(MAX_ITEMS)) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .in_is_last   (in_is_last),
    .out_valid    (out_valid),
    .out_rank     (out_rank),
    .out_last_rank(out_last_rank),
    .fail_cnt     (fail_cnt),
    .ranks_due    (ranks_due)
  );

  // Raise a request and hold it until the block takes it. busy is a register
  // output, so it is stable by the falling edge and tells whether the next
  // rising edge accepts. The task returns at that edge, leaving start high so
  // the caller decides with a single assignment what follows.
  task automatic send_item(input logic signed [31:0] v, input logic last);
    bit taken;
    start      <= 1'b1;
    in_value   <= v;
    in_is_last <= last;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    sent_cnt++;
  endtask

  // Drop start for the given number of cycles; the data lines carry junk meanwhile.
  task automatic idle_burst(input int unsigned cycles);
    start      <= 1'b0;
    in_value   <= $urandom;
    in_is_last <= 1'($urandom_range(0, 1));
    repeat (cycles) @(posedge clk);
  endtask

  // Send list_buf as one list, last flag on its final entry. Idle bursts fall
  // anywhere in the list, also between the last element and the next list.
  task automatic send_list(input bit may_idle);
    for (int i = 0; i < list_buf.size(); i++) begin
      if (may_idle && $urandom_range(0, 5) == 0)
        idle_burst($urandom_range(1, 9));
      send_item(list_buf[i], i == list_buf.size() - 1);
    end
  endtask

  // Mix of value flavors: narrow range for many ties, full range for every
  // bit pattern, and the two signed extremes with their neighbors.
  function automatic logic signed [31:0] pick_value(input int unsigned flavor);
    logic signed [31:0] v;
    case (flavor)
      0: v = $signed($urandom_range(0, 6)) - 3;
      1: v = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = VAL_MAX - 1;
          default: v = VAL_MIN + 1;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin
    int unsigned len;
    int unsigned flavor;
    bit          may_idle;

    // Synchronous reset held low from time zero, then released once.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single element at the negative extreme.
    list_buf = '{VAL_MIN};
    send_list(1'b0);
    // Extremes around zero, signed ordering across the sign bit.
    list_buf = '{VAL_MAX, VAL_MIN, 0, -1, 1};
    send_list(1'b0);
    // Ties mixed with distinct values: stable order among equals.
    list_buf = '{7, 7, -2, 7, -2};
    send_list(1'b1);
    // All equal: ranks follow arrival order.
    list_buf = '{0, 0, 0, 0};
    send_list(1'b0);
    // Alternating bit patterns and the single largest value alone.
    list_buf = '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0001};
    send_list(1'b1);
    list_buf = '{VAL_MAX};
    send_list(1'b0);

    // Random lists. Most are short; some fill the chain exactly, and some run
    // past it so the closing element is dropped but still closes the list.
    while (sent_cnt < ITEM_GOAL) begin
      case ($urandom_range(0, 19))
        0:       len = MAX_ITEMS;
        1:       len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
        2, 3, 4: len = $urandom_range(13, 40);
        default: len = $urandom_range(1, 12);
      endcase
      flavor   = $urandom_range(0, 2);
      may_idle = (sent_cnt < CALM_START) && ($urandom_range(0, 2) != 0);
      list_buf.delete();
      for (int i = 0; i < len; i++)
        list_buf.push_back(pick_value($urandom_range(0, 3) == 0 ? 2 : flavor));
      send_list(may_idle);
    end
    start <= 1'b0;

    // Drain: every queued rank must arrive, then allow a full list time for
    // stray results.
    while (ranks_due != 0) @(posedge clk);
    repeat (3 * MAX_ITEMS) @(posedge clk);

    if (fail_cnt == 0 && ranks_due == 0) begin
      $display("[value_rank_by_sort] OK");
    end else begin
      $display("[value_rank_by_sort] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #2_000_000;
    $display("[value_rank_by_sort] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

/* value_rank_by_sort.f */
hdl/vrs_pkg.sv
hdl/vrs_cell.sv
hdl/value_rank_by_sort.sv
hdl/vrs_checker.sv
tb/rank_checker.sv
tb/tb_top.sv
